>>> design/byte_budget_lru_cache_assert.svh
// Assertion macros for the byte budget LRU cache
`ifndef BYTE_BUDGET_LRU_CACHE_ASSERT_SVH
`define BYTE_BUDGET_LRU_CACHE_ASSERT_SVH
`define BBLC_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define BBLC_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

>>> design/bblc_pkg.sv
// Package for the byte budget LRU cache: constants, beat types, codes
package bblc_pkg;
	localparam int ENTRIES_DEF   = 16;
	localparam int SIZE_BITS_DEF = 24;
	localparam int KEY_BITS_DEF  = 32;
	localparam int CFG_BITS      = 24;
	localparam int SLOT_W        = 4;
	localparam logic [CFG_BITS-1:0] CAP_RESET = 24'd1048576;
	localparam logic [CFG_BITS-1:0] MAX_RESET = 24'd65536;
	localparam logic [2:0] KIND_HIT = 3'd0, KIND_MISS = 3'd1, KIND_INS = 3'd2,
		KIND_REJ = 3'd3, KIND_EVICT = 3'd4;
	localparam logic ACT_LOOKUP = 1'b0;
	localparam logic [0:0] REG_CAP = 1'b0, REG_MAX = 1'b1;
	typedef struct packed {
		logic        action;
		logic [31:0] key;
		logic [23:0] object_size;
	} in_beat_t;
	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  slot;
		logic [31:0] entry_key;
		logic [23:0] entry_size;
		logic        last;
	} out_beat_t;
endpackage

>>> design/byte_budget_lru_cache.sv
// Byte budget LRU cache top level: tables, sequencer, config and beat ports
// Lookup: the slots are scanned (SCAN, UPD) and DECIDE sends the result beat; a hit then
// runs the rank update in EMIT before the next beat is taken.
// Insert: one scan and one evict beat per eviction, then the fill and EMIT; reject: from IDLE.
// One request at a time; the compare unit is walked one slot per cycle.
// Reset: valid bits, ranks, byte count cleared; registers to their defaults.
module byte_budget_lru_cache import bblc_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int SIZE_BITS = SIZE_BITS_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_beat_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_beat_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	`include "byte_budget_lru_cache_assert.svh"
	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	typedef enum logic [2:0] {IDLE, SCAN, DECIDE, UPD, EMIT} state_t;
	state_t state_q;

	logic [CFG_BITS-1:0] cap_q, max_q;
	logic [KEY_BITS-1:0] keys_q [ENTRIES];
	logic [SIZE_BITS-1:0] sizes_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [IW-1:0] rank_q [ENTRIES];
	logic [SIZE_BITS-1:0] used_q;
	logic [CW-1:0] count_q;
	in_beat_t req_q;
	logic [IW-1:0] idx_q, tgt_q, tgt_rank_q;
	logic mode_q;
	out_beat_t out_q;
	logic out_v_q;

	logic scan_start, found;
	logic [IW-1:0] best, best_rank;
	logic [SIZE_BITS:0] need;
	logic [SIZE_BITS-1:0] rsize;
	logic [KEY_BITS-1:0] rkey;

	assign rsize = SIZE_BITS'(req_q.object_size);
	assign rkey = KEY_BITS'(req_q.key);
	assign need = {1'b0, used_q} + {1'b0, rsize};
	assign scan_start = (state_q == IDLE) || (state_q == DECIDE);

	bblc_scan #(.ENTRIES(ENTRIES)) u_scan (
		.clk, .arst_n, .start(scan_start), .mode_hit(mode_q),
		.step_valid(state_q == SCAN && valid_q[idx_q]),
		.step_match(keys_q[idx_q] == rkey),
		.idx(idx_q), .rank(rank_q[idx_q]),
		.found_q(found), .best_q(best), .best_rank_q(best_rank)
	);

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MAX) ? 32'(max_q) : 32'(cap_q);
	assign in_stall = (state_q != IDLE) || out_v_q;
	assign out_valid = out_v_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			max_q <= MAX_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_CAP) cap_q <= pwdata[CFG_BITS-1:0];
			else max_q <= pwdata[CFG_BITS-1:0];
		end
	end

	// first free slot
	logic [IW-1:0] free_slot;
	always_comb begin
		free_slot = '0;
		for (int i = ENTRIES - 1; i >= 0; i--)
			if (!valid_q[i]) free_slot = IW'(i);
	end

	logic over, full;
	assign over = need > {1'b0, SIZE_BITS'(cap_q)};
	assign full = count_q == CW'(ENTRIES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			valid_q <= '0;
			used_q <= '0;
			count_q <= '0;
			out_v_q <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
		end else begin
			if (out_v_q && !out_stall) out_v_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (in_valid && !in_stall) begin
						req_q <= in_data;
						idx_q <= '0;
						if (in_data.action == ACT_LOOKUP) begin
							mode_q <= 1'b1;
							state_q <= SCAN;
						end else if (in_data.object_size > max_q ||
							in_data.object_size > cap_q) begin
							out_q <= '{KIND_REJ, '0, in_data.key, in_data.object_size, 1'b1};
							out_v_q <= 1'b1;
						end else begin
							mode_q <= 1'b0;
							state_q <= DECIDE;
						end
					end
				end
				SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_IDX) state_q <= UPD;
				end
				DECIDE: begin
					if (!out_v_q || !out_stall) begin
						if (mode_q) begin
							if (!found)
								out_q <= '{KIND_MISS, '0, req_q.key, '0, 1'b1};
							else begin
								out_q <= '{KIND_HIT, SLOT_W'(best), 32'(keys_q[best]),
									24'(sizes_q[best]), 1'b1};
								tgt_q <= best;
								tgt_rank_q <= best_rank;
							end
							out_v_q <= 1'b1;
							idx_q <= '0;
							state_q <= found ? EMIT : IDLE;
						end else if ((over || full) && count_q != '0) begin
							idx_q <= '0;
							state_q <= SCAN;
						end else begin
							tgt_q <= free_slot;
							keys_q[free_slot] <= rkey;
							sizes_q[free_slot] <= rsize;
							used_q <= need[SIZE_BITS-1:0];
							out_q <= '{KIND_INS, SLOT_W'(free_slot), req_q.key,
								req_q.object_size, 1'b1};
							out_v_q <= 1'b1;
							idx_q <= '0;
							state_q <= EMIT;
						end
					end
				end
				UPD: begin
					if (mode_q) state_q <= DECIDE;
					else if (!out_v_q || !out_stall) begin
						valid_q[best] <= 1'b0;
						count_q <= count_q - 1'b1;
						used_q <= used_q - sizes_q[best];
						out_q <= '{KIND_EVICT, SLOT_W'(best), 32'(keys_q[best]),
							24'(sizes_q[best]), 1'b0};
						out_v_q <= 1'b1;
						state_q <= DECIDE;
					end
				end
				EMIT: begin
					// rank update, one slot per cycle
					if (mode_q) begin
						if (idx_q == tgt_q) rank_q[idx_q] <= '0;
						else if (valid_q[idx_q] && rank_q[idx_q] < tgt_rank_q)
							rank_q[idx_q] <= rank_q[idx_q] + 1'b1;
					end else begin
						if (idx_q == tgt_q) rank_q[idx_q] <= '0;
						else if (valid_q[idx_q]) rank_q[idx_q] <= rank_q[idx_q] + 1'b1;
					end
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_IDX) begin
						if (!mode_q) begin
							valid_q[tgt_q] <= 1'b1;
							count_q <= count_q + 1'b1;
						end
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	`BBLC_ASSERT_IMP(a_busy_stalls, clk, arst_n, state_q != IDLE, in_stall)
	`BBLC_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, count_q <= CW'(ENTRIES))
	`BBLC_ASSERT_NXT(a_hold_out, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_data))
endmodule

>>> design/bblc_scan.sv
// Shared per-slot compare unit: tests one slot per cycle against the search goal
module bblc_scan import bblc_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF,
	localparam int IW = $clog2(ENTRIES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                mode_hit,
	input  logic                step_valid,
	input  logic                step_match,
	input  logic [IW-1:0]       idx,
	input  logic [IW-1:0]       rank,
	output logic                found_q,
	output logic [IW-1:0]       best_q,
	output logic [IW-1:0]       best_rank_q
);
	logic better;
	always_comb begin
		if (mode_hit)
			better = step_valid && step_match && (!found_q || rank < best_rank_q);
		else
			better = step_valid && (!found_q || rank > best_rank_q);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (start) begin
			found_q <= 1'b0;
		end else if (better) begin
			found_q <= 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (better && !start) begin
			best_q <= idx;
			best_rank_q <= rank;
		end
	end
endmodule

>>> tb/sv/byte_budget_lru_cache_tb.sv
// Testbench for byte_budget_lru_cache: random and directed lookups and inserts against a model
`timescale 1ns / 100ps
module byte_budget_lru_cache_tb;
	import bblc_pkg::*;

	localparam int NSLOT = 16;
	localparam int QUIET = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_beat_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	byte_budget_lru_cache uut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	// cache model
	logic [23:0] cap_q, maxobj_q, bytes_q;
	logic [31:0] m_key[NSLOT];
	logic [23:0] m_size[NSLOT];
	logic m_valid[NSLOT];
	int unsigned m_rank[NSLOT];

	in_beat_t pending_reqs[$];
	out_beat_t expected_beats[$];
	int errors = 0, n_req = 0, n_evict = 0, n_hit = 0, n_rej = 0;
	bit quiet_tail = 0;
	int in_gap = 0, out_gap = 0;

	function automatic out_beat_t mk(logic [2:0] k, int s, logic [31:0] ky,
			logic [23:0] sz, logic l);
		out_beat_t b;
		b.kind = k; b.slot = s[3:0]; b.entry_key = ky; b.entry_size = sz; b.last = l;
		return b;
	endfunction

	task automatic predict_cache(input in_beat_t r);
		int hit, lru, cnt, fill;
		if (r.action == ACT_LOOKUP) begin
			hit = -1;
			for (int i = 0; i < NSLOT; i++)
				if (m_valid[i] && m_key[i] == r.key && (hit < 0 || m_rank[i] < m_rank[hit]))
					hit = i;
			if (hit < 0) begin
				expected_beats.push_back(mk(KIND_MISS, 0, r.key, '0, 1'b1));
				return;
			end
			for (int i = 0; i < NSLOT; i++)
				if (m_valid[i] && m_rank[i] < m_rank[hit]) m_rank[i]++;
			m_rank[hit] = 0;
			n_hit++;
			expected_beats.push_back(mk(KIND_HIT, hit, m_key[hit], m_size[hit], 1'b1));
			return;
		end
		if (r.object_size > maxobj_q || r.object_size > cap_q) begin
			n_rej++;
			expected_beats.push_back(mk(KIND_REJ, 0, r.key, r.object_size, 1'b1));
			return;
		end
		forever begin
			cnt = 0;
			lru = -1;
			for (int i = 0; i < NSLOT; i++)
				if (m_valid[i]) begin
					cnt++;
					if (lru < 0 || m_rank[i] > m_rank[lru]) lru = i;
				end
			if ({1'b0, bytes_q} + {1'b0, r.object_size} <= {1'b0, cap_q} && cnt < NSLOT)
				break;
			if (lru < 0) break;
			m_valid[lru] = 0;
			bytes_q = bytes_q - m_size[lru];
			n_evict++;
			expected_beats.push_back(mk(KIND_EVICT, lru, m_key[lru], m_size[lru], 1'b0));
		end
		fill = 0;
		for (int i = NSLOT - 1; i >= 0; i--)
			if (!m_valid[i]) fill = i;
		for (int i = 0; i < NSLOT; i++)
			if (m_valid[i]) m_rank[i]++;
		m_valid[fill] = 1; m_key[fill] = r.key; m_size[fill] = r.object_size;
		m_rank[fill] = 0;
		bytes_q = bytes_q + r.object_size;
		expected_beats.push_back(mk(KIND_INS, fill, r.key, r.object_size, 1'b1));
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_cache(in_data);
				n_req++;
				void'(pending_reqs.pop_front());
				if (!quiet_tail && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 18);
			end
			if (in_gap > 0 && !(in_valid && in_stall)) begin
				in_gap = in_gap - 1;
				in_valid <= 1'b0;
			end else if (!(in_valid && in_stall)) begin
				if (pending_reqs.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= pending_reqs[0];
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// result monitor and downstream stall
	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_beats.size() == 0) begin
					$error("unexpected result beat %p", out_data);
					errors++;
				end else begin
					e = expected_beats.pop_front();
					if (out_data.kind !== e.kind) begin
						$error("kind exp %0d got %0d", e.kind, out_data.kind); errors++;
					end
					if (out_data.slot !== e.slot) begin
						$error("slot exp %0d got %0d", e.slot, out_data.slot); errors++;
					end
					if (out_data.entry_key !== e.entry_key) begin
						$error("entry_key exp %h got %h", e.entry_key, out_data.entry_key);
						errors++;
					end
					if (out_data.entry_size !== e.entry_size) begin
						$error("entry_size exp %0d got %0d", e.entry_size, out_data.entry_size);
						errors++;
					end
					if (out_data.last !== e.last) begin
						$error("last exp %0d got %0d", e.last, out_data.last); errors++;
					end
				end
			end
			if (quiet_tail) begin
				out_stall <= 1'b0;
				out_gap <= 0;
			end else if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 7) == 0) begin
				out_gap <= $urandom_range(1, 18);
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
		end
	end

	task automatic reg_write(input logic [0:0] idx, input logic [23:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= {8'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == REG_CAP) cap_q = val; else maxobj_q = val;
	endtask

	task automatic drain;
		wait (pending_reqs.size() == 0 && !in_valid && expected_beats.size() == 0);
		repeat (QUIET) @(posedge clk);
	endtask

	function automatic in_beat_t req(logic a, logic [31:0] k, logic [23:0] s);
		in_beat_t b;
		b.action = a; b.key = k; b.object_size = s;
		return b;
	endfunction

	logic [31:0] key_pool[8];

	task automatic random_phase(input int n, input logic [23:0] szmax);
		logic [31:0] k;
		for (int i = 0; i < n; i++) begin
			k = ($urandom_range(0, 3) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
			if ($urandom_range(0, 1))
				pending_reqs.push_back(req(1'b1, k, 24'($urandom_range(0, szmax))));
			else
				pending_reqs.push_back(req(1'b0, k, 24'($urandom())));
		end
	endtask

	initial begin
		cap_q = CAP_RESET; maxobj_q = MAX_RESET; bytes_q = '0;
		for (int i = 0; i < NSLOT; i++) begin
			m_valid[i] = 0; m_rank[i] = 0; m_key[i] = '0; m_size[i] = '0;
		end
		for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// directed: miss on empty, zero size, duplicate keys, full table, rejects
		pending_reqs.push_back(req(1'b0, 32'hFFFF_FFFF, 24'hFFFFFF));
		pending_reqs.push_back(req(1'b1, 32'h0, 24'd0));
		pending_reqs.push_back(req(1'b1, 32'hFFFF_FFFF, 24'd65536));
		pending_reqs.push_back(req(1'b1, 32'h1234, 24'd65537));
		pending_reqs.push_back(req(1'b1, 32'h0, 24'd100));
		pending_reqs.push_back(req(1'b0, 32'h0, 24'd0));
		pending_reqs.push_back(req(1'b0, 32'hFFFF_FFFF, 24'd0));
		for (int i = 0; i < 15; i++)
			pending_reqs.push_back(req(1'b1, 32'(32'hA000 + i), 24'(1000 + i)));
		pending_reqs.push_back(req(1'b0, 32'hFFFF_FFFF, 24'd0));
		drain();
		// budget lowered below usage, then extremes
		reg_write(REG_CAP, 24'd5000);
		reg_write(REG_MAX, 24'hFFFFFF);
		pending_reqs.push_back(req(1'b1, 32'h5555_AAAA, 24'd4000));
		pending_reqs.push_back(req(1'b1, 32'h1, 24'd5001));
		pending_reqs.push_back(req(1'b1, 32'h2, 24'd5000));
		drain();
		reg_write(REG_CAP, 24'hFFFFFF);
		pending_reqs.push_back(req(1'b1, 32'h3, 24'hFFFFFF));
		pending_reqs.push_back(req(1'b1, 32'h4, 24'd1));
		drain();
		reg_write(REG_CAP, 24'd0);
		reg_write(REG_MAX, 24'd0);
		pending_reqs.push_back(req(1'b1, 32'h5, 24'd0));
		pending_reqs.push_back(req(1'b1, 32'h6, 24'd1));
		drain();
		// random: small budget forces eviction, large one keeps the table full
		reg_write(REG_CAP, 24'd3000);
		reg_write(REG_MAX, 24'd1500);
		random_phase(30, 24'd1800);
		drain();
		reg_write(REG_CAP, 24'hFFFFFF);
		reg_write(REG_MAX, 24'hFFFFFF);
		random_phase(30, 24'hFFFFFF);
		drain();
		reg_write(REG_CAP, CAP_RESET);
		reg_write(REG_MAX, MAX_RESET);
		quiet_tail = 1;
		random_phase(20, 24'd70000);
		drain();
		$display("%0d requests: %0d hits, %0d evictions, %0d rejects", n_req, n_hit,
			n_evict, n_rej);
		$display("register settings swept from zero to full scale");
		if (errors == 0)
			$display("PASS byte_budget_lru_cache");
		else
			$display("FAIL byte_budget_lru_cache");
		$finish;
	end

	initial begin
		#5000000;
		$display("FAIL byte_budget_lru_cache");
		$finish;
	end
endmodule

>>> files.f
+incdir+design
design/bblc_pkg.sv
design/bblc_scan.sv
design/byte_budget_lru_cache.sv
tb/sv/byte_budget_lru_cache_tb.sv
